FILE: rtl/ccs_pkg.sv
package ccs_pkg;

   localparam int unsigned STORE_DEPTH = 7;
   localparam int unsigned FILL_W      = 3;

   typedef enum logic [2:0] {
      PH_ADDR = 3'b001,
      PH_FUNC = 3'b010,
      PH_DATA = 3'b100
   } phase_type;

   typedef struct packed {
      logic [7:0] cmd_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [7:0] node_address;
      logic [7:0] packet_index;
      logic [3:0] length_code;
      logic [7:0] function_code;
      logic [7:0] payload_1;
      logic [7:0] payload_2;
      logic [7:0] payload_3;
      logic [7:0] payload_4;
      logic [7:0] payload_5;
      logic [7:0] payload_6;
      logic [7:0] payload_7;
      logic       final_frame;
   } frame_type;

   // framer status toward the top level
   typedef struct packed {
      logic pending;
      logic has_frame;
   } stat_type;

endpackage

FILE: rtl/ccs_if.sv
interface ccs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] cmd_byte;
   logic       is_last;

   modport source (output valid, output cmd_byte, output is_last, input ready);
   modport sink (input valid, input cmd_byte, input is_last, output ready);
endinterface

interface ccs_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] node_address;
   logic [7:0] packet_index;
   logic [3:0] length_code;
   logic [7:0] function_code;
   logic [7:0] payload_1;
   logic [7:0] payload_2;
   logic [7:0] payload_3;
   logic [7:0] payload_4;
   logic [7:0] payload_5;
   logic [7:0] payload_6;
   logic [7:0] payload_7;
   logic       final_frame;

   modport source (
      output valid, output node_address, output packet_index, output length_code,
      output function_code, output payload_1, output payload_2, output payload_3,
      output payload_4, output payload_5, output payload_6, output payload_7,
      output final_frame, input ready
   );
   modport sink (
      input valid, input node_address, input packet_index, input length_code,
      input function_code, input payload_1, input payload_2, input payload_3,
      input payload_4, input payload_5, input payload_6, input payload_7,
      input final_frame, output ready
   );
endinterface

FILE: rtl/ccs_in_stage.sv
module ccs_in_stage (
   input  logic             clock,
   input  logic             reset,
   ccs_req_if.sink          req_chan,
   input  logic             take,
   output logic             in_valid,
   output ccs_pkg::req_type in_data
);

   logic             valid_ff;
   logic             valid_in;
   ccs_pkg::req_type data_ff;
   logic             load;

   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;
   assign valid_in       = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff.cmd_byte <= req_chan.cmd_byte;
         data_ff.is_last  <= req_chan.is_last;
      end
   end

   assign in_valid = valid_ff;
   assign in_data  = data_ff;

endmodule

FILE: rtl/ccs_framer.sv
module ccs_framer #(
   parameter int unsigned PAYLOAD_PER_FRAME = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  ccs_pkg::req_type   in_data,
   input  logic               advance,
   output ccs_pkg::stat_type  stat,
   output ccs_pkg::frame_type frame
);

   localparam int unsigned GROUP_SIZE =
      (PAYLOAD_PER_FRAME >= 1 && PAYLOAD_PER_FRAME <= ccs_pkg::STORE_DEPTH) ?
      PAYLOAD_PER_FRAME : ccs_pkg::STORE_DEPTH;
   localparam logic [ccs_pkg::FILL_W-1:0] GROUP_FILL = ccs_pkg::FILL_W'(GROUP_SIZE);

   ccs_pkg::phase_type          phase_ff, phase_in;
   logic [7:0]                  addr_ff, addr_in;
   logic [7:0]                  func_ff, func_in;
   logic [ccs_pkg::FILL_W-1:0]  fill_ff, fill_in;
   logic [7:0]                  count_ff, count_in;
   logic [7:0]                  store_ff [ccs_pkg::STORE_DEPTH];
   logic [7:0]                  store_in [ccs_pkg::STORE_DEPTH];
   logic [7:0]                  merged   [ccs_pkg::STORE_DEPTH];
   logic [ccs_pkg::FILL_W-1:0]  fill_next;
   logic                        emit;

   assign fill_next = fill_ff + 1'b1;
   assign emit      = (phase_ff == ccs_pkg::PH_DATA) &&
                      (in_data.is_last || fill_next >= GROUP_FILL);

   // store holds zeros past the fill, so only the new byte is inserted
   always_comb begin
      for (int k = 0; k < ccs_pkg::STORE_DEPTH; k++) begin
         merged[k] = (fill_ff == ccs_pkg::FILL_W'(k)) ? in_data.cmd_byte : store_ff[k];
      end
   end

   always_comb begin
      phase_in = phase_ff;
      addr_in  = addr_ff;
      func_in  = func_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      store_in = store_ff;
      case (phase_ff)
         ccs_pkg::PH_ADDR: begin
            addr_in  = in_data.cmd_byte;
            phase_in = in_data.is_last ? ccs_pkg::PH_ADDR : ccs_pkg::PH_FUNC;
         end
         ccs_pkg::PH_FUNC: begin
            func_in  = in_data.cmd_byte;
            phase_in = in_data.is_last ? ccs_pkg::PH_ADDR : ccs_pkg::PH_DATA;
         end
         default: begin
            phase_in = ccs_pkg::PH_DATA;
            if (emit) begin
               fill_in = '0;
               for (int k = 0; k < ccs_pkg::STORE_DEPTH; k++) begin
                  store_in[k] = 8'h00;
               end
               if (in_data.is_last) begin
                  phase_in = ccs_pkg::PH_ADDR;
                  count_in = 8'h00;
               end else begin
                  count_in = count_ff + 8'h01;
               end
            end else begin
               fill_in  = fill_next;
               store_in = merged;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ccs_pkg::PH_ADDR;
         addr_ff  <= 8'h00;
         func_ff  <= 8'h00;
         fill_ff  <= '0;
         count_ff <= 8'h00;
         for (int k = 0; k < ccs_pkg::STORE_DEPTH; k++) begin
            store_ff[k] <= 8'h00;
         end
      end else if (advance) begin
         phase_ff <= phase_in;
         addr_ff  <= addr_in;
         func_ff  <= func_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
         store_ff <= store_in;
      end
   end

   assign stat.pending   = in_valid;
   assign stat.has_frame = in_valid && emit;

   assign frame.node_address  = addr_ff;
   assign frame.packet_index  = count_ff;
   assign frame.length_code   = {1'b0, fill_next} + 4'd1;
   assign frame.function_code = func_ff;
   assign frame.payload_1     = merged[0];
   assign frame.payload_2     = merged[1];
   assign frame.payload_3     = merged[2];
   assign frame.payload_4     = merged[3];
   assign frame.payload_5     = merged[4];
   assign frame.payload_6     = merged[5];
   assign frame.payload_7     = merged[6];
   assign frame.final_frame   = in_data.is_last;

endmodule

FILE: rtl/ccs_out_stage.sv
module ccs_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  ccs_pkg::frame_type frame,
   output logic               free,
   ccs_rsp_if.source          rsp_chan
);

   logic               valid_ff;
   logic               valid_in;
   ccs_pkg::frame_type data_ff;

   assign free     = !valid_ff || rsp_chan.ready;
   assign valid_in = load || (valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= frame;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.node_address  = data_ff.node_address;
   assign rsp_chan.packet_index  = data_ff.packet_index;
   assign rsp_chan.length_code   = data_ff.length_code;
   assign rsp_chan.function_code = data_ff.function_code;
   assign rsp_chan.payload_1     = data_ff.payload_1;
   assign rsp_chan.payload_2     = data_ff.payload_2;
   assign rsp_chan.payload_3     = data_ff.payload_3;
   assign rsp_chan.payload_4     = data_ff.payload_4;
   assign rsp_chan.payload_5     = data_ff.payload_5;
   assign rsp_chan.payload_6     = data_ff.payload_6;
   assign rsp_chan.payload_7     = data_ff.payload_7;
   assign rsp_chan.final_frame   = data_ff.final_frame;

endmodule

FILE: rtl/can_command_segmenter.sv
// Channel    Dir  Beat
// req_chan   in   cmd_byte, is_last: one command byte
// rsp_chan   out  one CAN extended frame (identifier parts, length, 8 data bytes)
//
// One byte per cycle sustained while no completed frame waits; a byte is held in
// the input register, then the framer updates its state and, when a frame
// completes, loads the result register. A frame is valid on rsp_chan once the
// result register holds it, after its last byte has passed the input register.
// Synchronous active-high reset clears phase, fill, counter and both valids.
// A byte that completes a frame waits only while the result register is full
// and not being taken; bytes that complete no frame never wait.
module can_command_segmenter #(
   parameter int unsigned PAYLOAD_PER_FRAME = 7
) (
   input  logic       clock,
   input  logic       reset,
   ccs_req_if.sink    req_chan,
   ccs_rsp_if.source  rsp_chan
);

   logic               in_valid;
   ccs_pkg::req_type   in_data;
   ccs_pkg::stat_type  stat;
   ccs_pkg::frame_type frame;
   logic               out_free;
   logic               take;

   assign take = stat.pending && (!stat.has_frame || out_free);

   ccs_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .in_valid (in_valid),
      .in_data  (in_data)
   );

   ccs_framer #(
      .PAYLOAD_PER_FRAME (PAYLOAD_PER_FRAME)
   ) u_framer (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid),
      .in_data  (in_data),
      .advance  (take),
      .stat     (stat),
      .frame    (frame)
   );

   ccs_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (take && stat.has_frame),
      .frame    (frame),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule
